// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Operation and status codes and shared types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t OP_ADD = 3'd0;
  localparam action_t OP_SUB = 3'd1;
  localparam action_t OP_MUL = 3'd2;
  localparam action_t OP_DIV = 3'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SAT   = 2'd1;
  localparam status_t ST_DIV0  = 2'd2;
  localparam status_t ST_BADOP = 2'd3;

  // control that travels beside the data through the divider stages
  typedef struct packed {
    action_t op;
    logic    div0;
  } cau_ctl_t;

endpackage

`default_nettype wire

// ===== design/cau_if.sv =====
// ----------------------------------------------------------------------------
// cau_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_in_if
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;
  action_t                      action;

  modport source (output valid, a_real, a_imag, b_real, b_imag, action, input ready);
  modport sink   (input valid, a_real, a_imag, b_real, b_imag, action, output ready);
endinterface

interface cau_out_if
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_real;
  logic signed [DATA_WIDTH-1:0] result_imag;
  status_t                      status;

  modport source (output valid, result_real, result_imag, status, input ready);
  modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

`default_nettype wire

// ===== design/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products and sums, per-operation combine, sign/magnitude split.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front
  import cau_pkg::*;
#(
  parameter int W = 16,
  parameter int F = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_i,
  input  wire logic signed [W-1:0]  ar_i,
  input  wire logic signed [W-1:0]  ai_i,
  input  wire logic signed [W-1:0]  br_i,
  input  wire logic signed [W-1:0]  bi_i,
  input  wire action_t              op_i,
  output logic                      valid_o,
  output cau_ctl_t                  ctl_o,
  output logic                      neg_r_o,
  output logic                      neg_i_o,
  output logic [2*W-1:0]            num_r_o,
  output logic [2*W-1:0]            num_i_o,
  output logic [W:0]                pass_r_o,
  output logic [W:0]                pass_i_o,
  output logic [2*W-1:0]            den_o
);

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam logic [PW-1:0] PASS_MAX = PW'(1) << W;

  logic [2:0] v_r;

  // stage 1
  logic signed [PW-1:0] arbr_r, aibi_r, arbi_r, aibr_r, brbr_r, bibi_r;
  logic signed [W:0]    sr_r, si_r;
  action_t              op1_r;

  // stage 2
  logic signed [SW-1:0] valr_r, vali_r, valr_nxt, vali_nxt;
  logic [PW-1:0]        den2_r;
  action_t              op2_r;

  // stage 3 comb
  logic          negr, negi;
  logic [SW-1:0] absr, absi;
  logic [PW-1:0] magr, magi, pmagr, pmagi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arbr_r <= ar_i * br_i;
      aibi_r <= ai_i * bi_i;
      arbi_r <= ar_i * bi_i;
      aibr_r <= ai_i * br_i;
      brbr_r <= br_i * br_i;
      bibi_r <= bi_i * bi_i;
      sr_r   <= (op_i == OP_SUB) ? ((W+1)'(ar_i) - (W+1)'(br_i))
                                 : ((W+1)'(ar_i) + (W+1)'(br_i));
      si_r   <= (op_i == OP_SUB) ? ((W+1)'(ai_i) - (W+1)'(bi_i))
                                 : ((W+1)'(ai_i) + (W+1)'(bi_i));
      op1_r  <= op_i;
    end
  end

  always_comb begin
    unique case (op1_r)
      OP_ADD, OP_SUB: begin
        valr_nxt = SW'(sr_r);
        vali_nxt = SW'(si_r);
      end
      OP_MUL: begin
        valr_nxt = SW'(arbr_r) - SW'(aibi_r);
        vali_nxt = SW'(arbi_r) + SW'(aibr_r);
      end
      OP_DIV: begin
        valr_nxt = SW'(arbr_r) + SW'(aibi_r);
        vali_nxt = SW'(aibr_r) - SW'(arbi_r);
      end
      default: begin
        valr_nxt = '0;
        vali_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      valr_r <= valr_nxt;
      vali_r <= vali_nxt;
      den2_r <= unsigned'(brbr_r) + unsigned'(bibi_r);
      op2_r  <= op1_r;
    end
  end

  // magnitudes reach at most 2^(2W-1), so 2W bits hold them
  always_comb begin
    negr  = valr_r[SW-1];
    negi  = vali_r[SW-1];
    absr  = negr ? unsigned'(-valr_r) : unsigned'(valr_r);
    absi  = negi ? unsigned'(-vali_r) : unsigned'(vali_r);
    magr  = absr[PW-1:0];
    magi  = absi[PW-1:0];
    // multiply drops fraction bits toward zero
    pmagr = (op2_r == OP_MUL) ? (magr >> F) : magr;
    pmagi = (op2_r == OP_MUL) ? (magi >> F) : magi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r_o     <= negr;
      neg_i_o     <= negi;
      num_r_o     <= magr;
      num_i_o     <= magi;
      pass_r_o    <= (pmagr > PASS_MAX) ? PASS_MAX[W:0] : pmagr[W:0];
      pass_i_o    <= (pmagi > PASS_MAX) ? PASS_MAX[W:0] : pmagi[W:0];
      den_o       <= den2_r;
      ctl_o.op    <= op2_r;
      ctl_o.div0  <= (den2_r == '0);
    end
  end

  assign valid_o = v_r[2];

endmodule

`default_nettype wire

// ===== design/cau_div_lane.sv =====
// ----------------------------------------------------------------------------
// cau_div_lane
// Pipelined restoring divider, one quotient bit per stage after the first, overflow to 2^W.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_lane #(
  parameter int W      = 16,
  parameter int F      = 8,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire logic [2*W-1:0]    num_i,
  input  wire logic [2*W-1:0]    den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [W:0]             quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int RW = 2 * W + F;
  localparam int CW = 3 * W + F;
  localparam int NS = W + 1;

  logic [NS-1:0]     v_r;
  logic [RW-1:0]     rem_r  [NS];
  logic [2*W-1:0]    den_r  [NS];
  logic [W-1:0]      q_r    [NS];
  logic              ovf_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];

  logic [RW-1:0] num_sh;
  logic          ovf0;

  // quotient of 2^W or more saturates anyway
  assign num_sh = RW'(num_i) << F;
  assign ovf0   = CW'(num_sh) >= (CW'(den_i) << W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_sh;
      den_r[0]  <= den_i;
      q_r[0]    <= '0;
      ovf_r[0]  <= ovf0;
      side_r[0] <= side_i;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam int K = W - j;
    logic [CW-1:0] dsh;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [W-1:0]  q_nxt;

    always_comb begin
      dsh     = CW'(den_r[j-1]) << K;
      ge      = CW'(rem_r[j-1]) >= dsh;
      rem_nxt = ge ? (rem_r[j-1] - dsh[RW-1:0]) : rem_r[j-1];
      q_nxt   = q_r[j-1];
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_r[j-1];
        q_r[j]    <= q_nxt;
        ovf_r[j]  <= ovf_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign valid_o = v_r[NS-1];
  assign quot_o  = ovf_r[NS-1] ? ((W+1)'(1) << W) : {1'b0, q_r[NS-1]};
  assign side_o  = side_r[NS-1];

endmodule

`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// When not held, one item per cycle goes in and one result per cycle comes out,
// through three front stages (products, combine, magnitude), DATA_WIDTH + 1
// divider stages, all but the first retiring one quotient bit each, and the
// saturating output register. The whole pipeline holds while a result waits
// on out_ch.ready; nothing is dropped or repeated.
`default_nettype none

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  localparam int W = DATA_WIDTH;
  localparam logic [W:0] LIM = (W+1)'(1) << (W-1);
  localparam int SIDE_R = $bits(cau_ctl_t) + 1 + (W + 1);
  localparam int SIDE_I = 1 + (W + 1);

  logic adv;
  logic out_valid_r;
  logic signed [W-1:0] res_r_r, res_i_r;
  status_t status_r;

  logic            f_valid;
  cau_ctl_t        f_ctl, l_ctl;
  logic            f_negr, f_negi, l_negr, l_negi;
  logic [2*W-1:0]  f_numr, f_numi, f_den;
  logic [W:0]      f_passr, f_passi, l_passr, l_passi;
  logic            vr, vi;
  logic [W:0]      qr, qi;
  logic [SIDE_R-1:0] sider;
  logic [SIDE_I-1:0] sidei;

  logic [W:0]          magr, magi;
  logic [W:0]          satr, sati;
  logic signed [W-1:0] res_r_nxt, res_i_nxt;
  status_t             status_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  cau_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk, .rst_n, .en(adv),
    .valid_i(in_ch.valid),
    .ar_i(in_ch.a_real), .ai_i(in_ch.a_imag),
    .br_i(in_ch.b_real), .bi_i(in_ch.b_imag),
    .op_i(in_ch.action),
    .valid_o(f_valid), .ctl_o(f_ctl),
    .neg_r_o(f_negr), .neg_i_o(f_negi),
    .num_r_o(f_numr), .num_i_o(f_numi),
    .pass_r_o(f_passr), .pass_i_o(f_passi),
    .den_o(f_den)
  );

  cau_div_lane #(.W(W), .F(FRAC_BITS), .SIDE_W(SIDE_R)) u_div_re (
    .clk, .rst_n, .en(adv), .valid_i(f_valid),
    .num_i(f_numr), .den_i(f_den), .side_i({f_ctl, f_negr, f_passr}),
    .valid_o(vr), .quot_o(qr), .side_o(sider)
  );

  cau_div_lane #(.W(W), .F(FRAC_BITS), .SIDE_W(SIDE_I)) u_div_im (
    .clk, .rst_n, .en(adv), .valid_i(f_valid),
    .num_i(f_numi), .den_i(f_den), .side_i({f_negi, f_passi}),
    .valid_o(vi), .quot_o(qi), .side_o(sidei)
  );

  assign {l_ctl, l_negr, l_passr} = sider;
  assign {l_negi, l_passi}        = sidei;

  // clamp a sign/magnitude part; top bit of the result is the overflow flag
  function automatic logic [W:0] sat_part(input logic neg, input logic [W:0] mag);
    logic [W:0] m;
    logic       fl;
    m  = mag;
    fl = 1'b0;
    if (neg) begin
      if (mag > LIM) begin
        fl = 1'b1;
        m  = LIM;
      end
      m = -m;
    end else if (mag > LIM - 1'b1) begin
      fl = 1'b1;
      m  = LIM - 1'b1;
    end
    return {fl, m[W-1:0]};
  endfunction

  always_comb begin
    magr = (l_ctl.op == OP_DIV) ? qr : l_passr;
    magi = (l_ctl.op == OP_DIV) ? qi : l_passi;
    satr = sat_part(l_negr, magr);
    sati = sat_part(l_negi, magi);
    res_r_nxt  = satr[W-1:0];
    res_i_nxt  = sati[W-1:0];
    status_nxt = (satr[W] || sati[W]) ? ST_SAT : ST_OK;
    priority if (l_ctl.op != OP_ADD && l_ctl.op != OP_SUB &&
                 l_ctl.op != OP_MUL && l_ctl.op != OP_DIV) begin
      res_r_nxt  = '0;
      res_i_nxt  = '0;
      status_nxt = ST_BADOP;
    end else if (l_ctl.op == OP_DIV && l_ctl.div0) begin
      res_r_nxt  = '0;
      res_i_nxt  = '0;
      status_nxt = ST_DIV0;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vr && vi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r_r  <= res_r_nxt;
      res_i_r  <= res_i_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_real = res_r_r;
  assign out_ch.result_imag = res_i_r;
  assign out_ch.status      = status_r;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) vr == vi)
    else $error("divider lanes out of step");
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
      !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input stalled without a waiting result");
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && status_r == ST_DIV0) |-> (res_r_r == '0 && res_i_r == '0))
    else $error("divide by zero result not cleared");
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives operand items through the unit and compares every result item with a
// local predictor or the result typed in the table; a short operand table first,
// then random traffic with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int NUM_RANDOM = 1030;

  typedef struct {
    logic signed [DW-1:0] ar, ai, br, bi;
    action_t              act;
  } operand_t;

  typedef struct {
    logic signed [DW-1:0] rr, ri;
    status_t              st;
  } result_t;

  typedef struct {
    operand_t op;
    logic     known;   // expected result typed in the table
    result_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  bit   feed_done = 1'b0;
  result_t pending_results[$];

  cau_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  cau_out_if #(.DATA_WIDTH(DW)) out_ch ();

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // clamp to the signed range; sets sat on overflow
  function automatic logic signed [DW-1:0] clamp(input longint v, inout bit sat);
    longint hi;
    hi = (longint'(1) << (DW-1)) - 1;
    if (v > hi) begin
      sat = 1'b1;
      return DW'(hi);
    end
    if (v < -hi - 1) begin
      sat = 1'b1;
      return DW'(-hi - 1);
    end
    return DW'(v);
  endfunction

  // truncating (num * 2^FB) / den, held just past the bound
  function automatic longint frac_quotient(input longint num, input longint den);
    longint cap, mag, q;
    cap = (longint'(1) << (DW-1)) + 1;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    if (q > cap) q = cap;
    else begin
      q = (mag << FB) / den;  // fits: |num| <= 2^31, scaled <= 2^39
      if (q > cap) q = cap;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic result_t complex_result(input operand_t o);
    result_t r;
    bit sat;
    longint ar, ai, br, bi, pr, pi, den;
    ar = o.ar; ai = o.ai; br = o.br; bi = o.bi;
    sat = 1'b0;
    r.rr = '0; r.ri = '0; r.st = ST_OK;
    case (o.act)
      OP_ADD: begin
        r.rr = clamp(ar + br, sat);
        r.ri = clamp(ai + bi, sat);
      end
      OP_SUB: begin
        r.rr = clamp(ar - br, sat);
        r.ri = clamp(ai - bi, sat);
      end
      OP_MUL: begin
        pr = ar * br - ai * bi;
        pi = ar * bi + ai * br;
        // shift magnitude, i.e. truncate toward zero
        pr = (pr < 0) ? -((-pr) >>> FB) : (pr >>> FB);
        pi = (pi < 0) ? -((-pi) >>> FB) : (pi >>> FB);
        r.rr = clamp(pr, sat);
        r.ri = clamp(pi, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = ST_DIV0;
        else begin
          r.rr = clamp(frac_quotient(ar * br + ai * bi, den), sat);
          r.ri = clamp(frac_quotient(ai * br - ar * bi, den), sat);
        end
      end
      default: r.st = ST_BADOP;
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic operand_t mk(input int ar, ai, br, bi, input action_t act);
    operand_t o;
    o.ar = DW'(ar); o.ai = DW'(ai); o.br = DW'(br); o.bi = DW'(bi); o.act = act;
    return o;
  endfunction

  function automatic row_t row(input operand_t o, input logic known, input int rr = 0,
                               input int ri = 0, input status_t st = ST_OK);
    row_t t;
    t.op = o; t.known = known;
    t.res.rr = DW'(rr); t.res.ri = DW'(ri); t.res.st = st;
    return t;
  endfunction

  function automatic logic signed [DW-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return DW'(int'($urandom_range(0, 1023)) - 512);  // small values
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic send(input operand_t o);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.a_real <= o.ar;
    in_ch.a_imag <= o.ai;
    in_ch.b_real <= o.br;
    in_ch.b_imag <= o.bi;
    in_ch.action <= o.act;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    row_t    rows[$];
    operand_t o;
    result_t pr;
    in_ch.valid = 1'b0;
    in_ch.a_real = '0; in_ch.a_imag = '0; in_ch.b_real = '0; in_ch.b_imag = '0;
    in_ch.action = OP_ADD;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back(row(mk(256, 512, 256, -256, OP_ADD), 1, 512, 256, ST_OK));
    rows.push_back(row(mk(32767, 32767, 1, 1, OP_ADD), 1, 32767, 32767, ST_SAT));
    rows.push_back(row(mk(-32768, -32768, -1, -1, OP_ADD), 1, -32768, -32768, ST_SAT));
    rows.push_back(row(mk(-32768, 32767, 1, -1, OP_SUB), 1, -32768, 32767, ST_SAT));
    rows.push_back(row(mk(100, -100, 50, 25, OP_SUB), 1, 50, -125, ST_OK));
    rows.push_back(row(mk(512, 0, 512, 0, OP_MUL), 1, 1024, 0, ST_OK));
    rows.push_back(row(mk(-32768, -32768, -32768, -32768, OP_MUL), 0));
    rows.push_back(row(mk(32767, -32768, 32767, 32767, OP_MUL), 0));
    rows.push_back(row(mk(-1, 1, 1, 1, OP_MUL), 0));
    rows.push_back(row(mk(256, 256, 0, 0, OP_DIV), 1, 0, 0, ST_DIV0));
    rows.push_back(row(mk(-32768, 32767, 0, 0, OP_DIV), 1, 0, 0, ST_DIV0));
    rows.push_back(row(mk(512, 256, 256, 0, OP_DIV), 1, 512, 256, ST_OK));
    rows.push_back(row(mk(32767, 32767, 1, 0, OP_DIV), 1, 32767, 32767, ST_SAT));
    rows.push_back(row(mk(-32768, 32767, 1, 1, OP_DIV), 0));
    rows.push_back(row(mk(-32768, -32768, -32768, -32768, OP_DIV), 0));
    rows.push_back(row(mk(1, -1, 32767, -32768, OP_DIV), 0));
    rows.push_back(row(mk(-7, 3, 5, -9, OP_DIV), 0));
    rows.push_back(row(mk(1, 2, 3, 4, 3'd4), 1, 0, 0, ST_BADOP));
    rows.push_back(row(mk(-1, -1, -1, -1, 3'd5), 1, 0, 0, ST_BADOP));
    rows.push_back(row(mk(5, 5, 5, 5, 3'd6), 1, 0, 0, ST_BADOP));
    rows.push_back(row(mk(32767, -32768, 0, 0, 3'd7), 1, 0, 0, ST_BADOP));

    foreach (rows[i]) begin
      pr = complex_result(rows[i].op);
      if (rows[i].known && (pr.rr !== rows[i].res.rr || pr.ri !== rows[i].res.ri ||
                            pr.st !== rows[i].res.st))
        report_mismatch("table row vs predictor", i, pr.rr);
      pending_results.push_back(rows[i].known ? rows[i].res : pr);
      send(rows[i].op);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      o.ar = rand_part(); o.ai = rand_part(); o.br = rand_part(); o.bi = rand_part();
      o.act = ($urandom_range(0, 9) == 0) ? action_t'($urandom_range(4, 7))
                                          : action_t'($urandom_range(0, 3));
      if (o.act == OP_DIV && $urandom_range(0, 15) == 0) begin
        o.br = '0; o.bi = '0;
      end
      pending_results.push_back(complex_result(o));
      send(o);
    end
    in_ch.valid <= 1'b0;
    feed_done = 1'b1;
  end

  // result side
  initial begin
    int      gap;
    result_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 5);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.result_real, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_real !== want.rr)
          report_mismatch("result_real", out_ch.result_real, want.rr);
        if (out_ch.result_imag !== want.ri)
          report_mismatch("result_imag", out_ch.result_imag, want.ri);
        if (out_ch.status !== want.st)
          report_mismatch("status", out_ch.status, want.st);
      end
    end
  end

  // finish
  initial begin
    wait (feed_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DW + 20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
